### hdl/fsvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvf_pkg: shared definitions for the state-variable filter
// Widths, register indexes, rounding codes, sequencer states and the
// damping-factor table used by the filter top level and its multiply unit.
// ----------------------------------------------------------------------------
package fsvf_pkg;

    // Datapath widths
    localparam int STATE_BITS   = 40;
    localparam int PROD_W       = 64;
    localparam int HALF_W       = PROD_W / 2;
    localparam int PROD_IDX_W   = $clog2(PROD_W);
    localparam int SAMPLE_W     = 16;
    localparam int SAMPLE_SHIFT = 3;
    localparam int PRELOAD_W    = 40;
    localparam int MIX_W        = 32;
    localparam int SHIFT_W      = 5;
    localparam int RAW_W        = 25;
    localparam int COEF_W       = 32;
    localparam int QPROD_W      = 36;
    localparam int Q_FRAC_BITS  = 3;
    localparam int SH_W         = 7;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Config field widths
    localparam int FREQ_CODE_W = 13;
    localparam int MANT_W      = 9;
    localparam int EXP_W       = 4;
    localparam int Q_CODE_W    = 2;
    localparam int MODES_W     = 8;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_FREQ_CODE  = 3'd0;
    localparam reg_idx_t REG_Q_CODE     = 3'd1;
    localparam reg_idx_t REG_FREQ_BITS  = 3'd2;
    localparam reg_idx_t REG_DAMP_BITS  = 3'd3;
    localparam reg_idx_t REG_DAMP_MODE  = 3'd4;
    localparam reg_idx_t REG_ROUND_MODE = 3'd5;

    // Rounding of a product shifted right
    typedef enum logic [1:0] {
        RND_FLOOR   = 2'd0,
        RND_ZERO    = 2'd1,
        RND_HALF_UP = 2'd2,
        RND_CEIL    = 2'd3
    } rnd_mode_t;

    // Which of the four products is in flight
    typedef enum logic [1:0] {
        P_INPUT = 2'd0,
        P_LOW   = 2'd1,
        P_DAMP  = 2'd2,
        P_BAND  = 2'd3
    } prod_t;

    // Multiply unit phases
    typedef enum logic [2:0] {
        M_IDLE,
        M_LL,
        M_LH,
        M_HL,
        M_ADD,
        M_RND
    } mac_state_t;

    // Filter sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_SCALE,
        S_SHIFT,
        S_START,
        S_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        rnd_mode_t            mode;
        logic [SHIFT_W-1:0]   shift;
    } mac_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mac_rsp_t;

    // Damping factor in eighths: 1.5, 1.0, 0.75, 0.375
    function automatic logic [3:0] q_eighths(input logic [Q_CODE_W-1:0] code);
        logic [3:0] val;
        begin
            case (code)
                2'd0:    val = 4'd12;
                2'd1:    val = 4'd8;
                2'd2:    val = 4'd6;
                default: val = 4'd3;
            endcase
            return val;
        end
    endfunction

endpackage

### hdl/fsvf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsvf_mac: shared multiply and round unit
// Forms a 64-bit product modulo 2^64 from three passes through one 32x32
// multiplier, then shifts it right by a variable amount under a rounding mode.
// ----------------------------------------------------------------------------
module fsvf_mac
    import fsvf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_req_t              req,
    input  logic [PROD_W-1:0]     op_a,
    input  logic [PROD_W-1:0]     op_b,
    output mac_rsp_t              rsp,
    output logic [STATE_BITS-1:0] result
);

    mac_state_t              state_reg;
    mac_state_t              state_next;
    logic [PROD_W-1:0]       a_reg;
    logic [PROD_W-1:0]       b_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    rnd_mode_t               mode_reg;
    logic [PROD_W-1:0]       mul_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [STATE_BITS-1:0]   res_reg;
    logic                    done_reg;

    logic [HALF_W-1:0]       mul_x;
    logic [HALF_W-1:0]       mul_y;
    logic [PROD_W-1:0]       mul_prod;
    logic [PROD_W-1:0]       floor_val;
    logic [PROD_W-1:0]       rest_mask;
    logic [PROD_IDX_W-1:0]   half_idx;
    logic                    rest_nz;
    logic                    round_up;
    logic [STATE_BITS-1:0]   rounded;

    // Advance through the partial products
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    state_next = M_LL;
                end
            end
            M_LL:    state_next = M_LH;
            M_LH:    state_next = M_HL;
            M_HL:    state_next = M_ADD;
            M_ADD:   state_next = M_RND;
            M_RND:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    // Steer the multiplier halves for each pass
    always_comb
    begin
        mul_x = a_reg[HALF_W-1:0];
        mul_y = b_reg[HALF_W-1:0];
        case (state_reg)
            M_LH:    mul_y = b_reg[PROD_W-1:HALF_W];
            M_HL:    mul_x = a_reg[PROD_W-1:HALF_W];
            default: ;
        endcase
    end

    assign mul_prod = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

    // Shift right with rounding; a zero shift passes the product through
    always_comb
    begin
        floor_val = PROD_W'($signed(acc_reg) >>> shift_reg);
        rest_mask = (PROD_W'(1) << shift_reg) - PROD_W'(1);
        rest_nz   = |(acc_reg & rest_mask);
        half_idx  = {1'b0, shift_reg - SHIFT_W'(1)};
        case (mode_reg)
            RND_FLOOR:   round_up = 1'b0;
            RND_ZERO:    round_up = acc_reg[PROD_W-1] && rest_nz;
            RND_HALF_UP: round_up = acc_reg[half_idx];
            RND_CEIL:    round_up = rest_nz;
            default:     round_up = 1'b0;
        endcase
        if (shift_reg == '0)
        begin
            rounded = acc_reg[STATE_BITS-1:0];
        end
        else
        begin
            rounded = floor_val[STATE_BITS-1:0] + STATE_BITS'(round_up);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_RND);
        end
    end

    // Operands, partial products and rounded result
    always_ff @(posedge clk)
    begin
        if (req.start && state_reg == M_IDLE)
        begin
            a_reg     <= op_a;
            b_reg     <= op_b;
            shift_reg <= req.shift;
            mode_reg  <= req.mode;
        end
        case (state_reg)
            M_LL:
            begin
                mul_reg <= mul_prod;
            end
            M_LH:
            begin
                acc_reg <= mul_reg;
                mul_reg <= mul_prod;
            end
            M_HL:
            begin
                acc_reg[PROD_W-1:HALF_W] <= acc_reg[PROD_W-1:HALF_W] + mul_reg[HALF_W-1:0];
                mul_reg                  <= mul_prod;
            end
            M_ADD:
            begin
                acc_reg[PROD_W-1:HALF_W] <= acc_reg[PROD_W-1:HALF_W] + mul_reg[HALF_W-1:0];
            end
            M_RND:
            begin
                res_reg <= rounded;
            end
            default: ;
        endcase
    end

    assign rsp.busy = (state_reg != M_IDLE);
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

### hdl/fixed_point_state_variable_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_state_variable_filter_unit: fixed-point state-variable low-pass
// Chamberlin low-pass with per-product rounding, programmable coefficients
// and a preload request that sets the low and band states directly.
//
// Sequence: a filter request steps through the coefficient states (COEF,
//   SCALE, SHIFT), then through each product (start, three 32x32 passes,
//   add, round, hand-off), then the output state; a preload goes straight
//   to the output state. A new request is taken only once the sequencer is
//   idle again after loading its result; an output stall holds it meanwhile.
// Reset: rst_n clears both states and loads the register defaults at once.
// ----------------------------------------------------------------------------
module fixed_point_state_variable_filter_unit
    import fsvf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic signed [PRELOAD_W-1:0] preload_low,
    input  logic signed [PRELOAD_W-1:0] preload_band,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [MIX_W-1:0]     mix_out
);

    localparam logic [SHIFT_W-1:0] RAW_SHIFT   = SHIFT_W'(RAW_W);
    localparam logic [SH_W-1:0]    Q_FRAC_SH   = SH_W'(Q_FRAC_BITS);
    localparam logic [SH_W-1:0]    RAW_Q_SH    = SH_W'(RAW_W + Q_FRAC_BITS);

    // Configuration registers
    logic [FREQ_CODE_W-1:0]   freq_code_reg;
    logic [Q_CODE_W-1:0]      q_code_reg;
    logic [SHIFT_W-1:0]       freq_bits_reg;
    logic [SHIFT_W-1:0]       damp_bits_reg;
    logic                     damp_mode_reg;
    logic [MODES_W-1:0]       round_modes_reg;

    // Sequencer and datapath
    seq_state_t               state_reg;
    seq_state_t               state_next;
    prod_t                    idx_reg;
    prod_t                    idx_next;
    logic [STATE_BITS-1:0]    low_acc_reg;
    logic [STATE_BITS-1:0]    band_acc_reg;
    logic [STATE_BITS-1:0]    sum_reg;
    logic [SAMPLE_W-1:0]      x_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic [COEF_W-1:0]        f_reg;
    logic [QPROD_W-1:0]       qprod_reg;
    logic [PROD_W-1:0]        fq_reg;
    logic [MIX_W-1:0]         mix_reg;
    logic                     out_valid_reg;

    logic                     cfg_write;
    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic                     mac_start;
    logic [RAW_W-1:0]         raw_calc;
    logic [COEF_W-1:0]        f_calc;
    logic [COEF_W-1:0]        scale_src;
    logic [SH_W-1:0]          sh_calc;
    logic [PROD_IDX_W-1:0]    sh_right;
    logic [PROD_W-1:0]        fq_calc;
    logic [PROD_W-1:0]        f_ext;
    logic [PROD_W-1:0]        x_ext;
    logic [PROD_W-1:0]        low_ext;
    logic [PROD_W-1:0]        band_ext;
    logic [PROD_W-1:0]        op_a;
    logic [PROD_W-1:0]        op_b;
    mac_req_t                 mac_req;
    mac_rsp_t                 mac_rsp;
    logic [STATE_BITS-1:0]    mac_result;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_code_reg   <= '0;
            q_code_reg      <= Q_CODE_W'(1);
            freq_bits_reg   <= SHIFT_W'(12);
            damp_bits_reg   <= SHIFT_W'(12);
            damp_mode_reg   <= 1'b0;
            round_modes_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_FREQ_CODE:  freq_code_reg   <= pwdata[FREQ_CODE_W-1:0];
                REG_Q_CODE:     q_code_reg      <= pwdata[Q_CODE_W-1:0];
                REG_FREQ_BITS:  freq_bits_reg   <= pwdata[SHIFT_W-1:0];
                REG_DAMP_BITS:  damp_bits_reg   <= pwdata[SHIFT_W-1:0];
                REG_DAMP_MODE:  damp_mode_reg   <= pwdata[0];
                REG_ROUND_MODE: round_modes_reg <= pwdata[MODES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FREQ_CODE:  prdata = DATA_W'(freq_code_reg);
            REG_Q_CODE:     prdata = DATA_W'(q_code_reg);
            REG_FREQ_BITS:  prdata = DATA_W'(freq_bits_reg);
            REG_DAMP_BITS:  prdata = DATA_W'(damp_bits_reg);
            REG_DAMP_MODE:  prdata = DATA_W'(damp_mode_reg);
            REG_ROUND_MODE: prdata = DATA_W'(round_modes_reg);
            default:        prdata = '0;
        endcase
    end

    // Frequency coefficient from exponent and mantissa
    always_comb
    begin
        raw_calc = RAW_W'({1'b1, freq_code_reg[MANT_W-1:0]})
                   << freq_code_reg[FREQ_CODE_W-1:MANT_W];
        if (freq_bits_reg < RAW_SHIFT)
        begin
            f_calc = COEF_W'(raw_reg >> (RAW_SHIFT - freq_bits_reg));
        end
        else
        begin
            f_calc = COEF_W'(raw_reg) << (freq_bits_reg - RAW_SHIFT);
        end
    end

    // Damping coefficient: scale by q, then align to its fraction bits
    always_comb
    begin
        scale_src = damp_mode_reg ? COEF_W'(raw_reg) : f_calc;
        if (damp_mode_reg)
        begin
            sh_calc = SH_W'(damp_bits_reg) - RAW_Q_SH;
        end
        else
        begin
            sh_calc = SH_W'(damp_bits_reg) - SH_W'(freq_bits_reg) - Q_FRAC_SH;
        end
        sh_right = PROD_IDX_W'(SH_W'(0) - sh_calc);
        if (sh_calc[SH_W-1])
        begin
            fq_calc = PROD_W'(qprod_reg) >> sh_right;
        end
        else
        begin
            fq_calc = PROD_W'(qprod_reg) << sh_calc[PROD_IDX_W-1:0];
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        f_ext    = PROD_W'(f_reg);
        x_ext    = {{(PROD_W-SAMPLE_W-SAMPLE_SHIFT){x_reg[SAMPLE_W-1]}}, x_reg,
                    {SAMPLE_SHIFT{1'b0}}};
        low_ext  = {{(PROD_W-STATE_BITS){low_acc_reg[STATE_BITS-1]}}, low_acc_reg};
        band_ext = {{(PROD_W-STATE_BITS){band_acc_reg[STATE_BITS-1]}}, band_acc_reg};
        op_a          = f_ext;
        op_b          = band_ext;
        mac_req.shift = freq_bits_reg;
        case (idx_reg)
            P_INPUT: op_b = x_ext;
            P_LOW:   op_b = low_ext;
            P_DAMP:
            begin
                op_a          = fq_reg;
                mac_req.shift = damp_bits_reg;
            end
            default: ;
        endcase
        mac_req.mode  = rnd_mode_t'(round_modes_reg[{idx_reg, 1'b0} +: 2]);
        mac_req.start = mac_start;
    end

    fsvf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .op_a   (op_a),
        .op_b   (op_b),
        .rsp    (mac_rsp),
        .result (mac_result)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? S_OUT : S_COEF;
                end
            end
            S_COEF:  state_next = S_SCALE;
            S_SCALE: state_next = S_SHIFT;
            S_SHIFT:
            begin
                state_next = S_START;
                idx_next   = P_INPUT;
            end
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    state_next = S_START;
                    case (idx_reg)
                        P_INPUT: idx_next = P_LOW;
                        P_LOW:   idx_next = P_DAMP;
                        P_DAMP:  idx_next = P_BAND;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ready  = 1'b0;
        mac_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready  = 1'b1;
            S_START: mac_start = 1'b1;
            S_OUT:   out_load  = out_free;
            default: ;
        endcase
    end

    assign accept = in_valid && in_ready;

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= P_INPUT;
            low_acc_reg   <= '0;
            band_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            // Preload both states straight from the request
            if (accept && action)
            begin
                low_acc_reg  <= STATE_BITS'($signed(preload_low));
                band_acc_reg <= STATE_BITS'($signed(preload_band));
            end
            // Commit band after the damping term, low after the last product
            if (state_reg == S_WAIT && mac_rsp.done)
            begin
                case (idx_reg)
                    P_DAMP:  band_acc_reg <= sum_reg - mac_result;
                    P_BAND:  low_acc_reg  <= low_acc_reg + mac_result;
                    default: ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample;
        end
        case (state_reg)
            S_COEF:  raw_reg <= raw_calc;
            S_SCALE:
            begin
                f_reg     <= f_calc;
                qprod_reg <= QPROD_W'(q_eighths(q_code_reg)) * QPROD_W'(scale_src);
            end
            S_SHIFT:
            begin
                fq_reg  <= fq_calc;
                sum_reg <= band_acc_reg;
            end
            S_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    case (idx_reg)
                        P_INPUT: sum_reg <= sum_reg + mac_result;
                        P_LOW:   sum_reg <= sum_reg - mac_result;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            mix_reg <= MIX_W'(0) - {low_acc_reg[MIX_W-2:0], 1'b0};
        end
    end

    assign out_valid = out_valid_reg;
    assign mix_out   = mix_reg;

    // The multiply unit is idle whenever a new request is taken
    a_mac_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !mac_rsp.busy)
        else $error("multiply unit busy at request acceptance");

    // A product result only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_rsp.done |-> (state_reg == S_WAIT))
        else $error("product result outside wait state");

    // A result is only raised from the output state
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

endmodule
